>>> design/decode_sample_size_chooser_macros.svh
// Assertion macros shared by the checker of the decode sample size chooser.
`ifndef DECODE_SAMPLE_SIZE_CHOOSER_MACROS_SVH
`define DECODE_SAMPLE_SIZE_CHOOSER_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define DSSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks a property on every clock edge, reset included.
`define DSSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> design/dssc_pkg.sv
// Shared constants and types of the decode sample size chooser.
package dssc_pkg;

    localparam int DIM_BITS_DEFAULT = 16;
    localparam int IMG_W            = 16;
    localparam int SIDE_W           = 16;
    localparam int MAXPIX_W         = 32;
    localparam int SAMPLE_W         = 17;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 32;
    localparam int UNIT_W           = MAXPIX_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE_LENGTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE_ENABLED   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PIXELS         = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PIXELS_ENABLED = CFG_IDX_W'(3);

    localparam logic [SIDE_W-1:0]   RST_MIN_SIDE_LENGTH    = SIDE_W'(96);
    localparam logic                RST_MIN_SIDE_ENABLED   = 1'b0;
    localparam logic [MAXPIX_W-1:0] RST_MAX_PIXELS         = MAXPIX_W'(196608);
    localparam logic                RST_MAX_PIXELS_ENABLED = 1'b1;

    localparam logic [SAMPLE_W-1:0] SIDE_OFF_UPPER = SAMPLE_W'(128);
    localparam logic [SAMPLE_W-1:0] POW2_LIMIT     = SAMPLE_W'(8);
    localparam logic [SAMPLE_W:0]   ROUND_MASK     = (SAMPLE_W + 1)'(7);

    typedef struct packed {
        logic [SIDE_W-1:0]   min_side_length;
        logic                min_side_enabled;
        logic [MAXPIX_W-1:0] max_pixels;
        logic                max_pixels_enabled;
    } cfg_t;

endpackage

>>> design/dssc_core.sv
// Sequencer and shared subtract unit that compute the sample size.
module dssc_core #(
    parameter int DIM_BITS = dssc_pkg::DIM_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start_go,
    input  logic [DIM_BITS-1:0]           width_in,
    input  logic [DIM_BITS-1:0]           height_in,
    input  dssc_pkg::cfg_t                cfg,
    output logic                          busy,
    output logic                          done,
    output logic [dssc_pkg::SAMPLE_W-1:0] sample_size
);

    localparam int PW    = 2 * DIM_BITS;
    localparam int CNT_W = $clog2(PW);
    localparam int SW    = dssc_pkg::SAMPLE_W;
    localparam int MW    = dssc_pkg::MAXPIX_W;
    localparam int UW    = dssc_pkg::UNIT_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_DIVQ  = 4'd2;
    localparam logic [3:0] ST_QFIX  = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_SQFIX = 4'd5;
    localparam logic [3:0] ST_SIDE  = 4'd6;
    localparam logic [3:0] ST_DIVS  = 4'd7;
    localparam logic [3:0] ST_FINAL = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DIM_BITS-1:0] w_reg, w_next;
    logic [DIM_BITS-1:0] h_reg, h_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [MW-1:0]       rem_reg, rem_next;
    logic [DIM_BITS-1:0] root_reg, root_next;
    logic [SW-1:0]       lower_reg, lower_next;
    logic [SW-1:0]       sample_reg, sample_next;

    logic [dssc_pkg::SIDE_W-1:0] side_eff;
    logic [MW-1:0]               mp_eff;
    logic [DIM_BITS-1:0]         min_dim;
    logic [UW-1:0]               a_op, b_op, diff;
    logic                        borrow, fits;
    logic [MW-1:0]               rem_step;
    logic [SW-1:0]               upper_val, initial_val, rounded;
    logic [SW:0]                 round_sum;

    assign side_eff = (cfg.min_side_length == '0) ? dssc_pkg::SIDE_W'(1) : cfg.min_side_length;
    assign mp_eff   = (cfg.max_pixels == '0) ? MW'(1) : cfg.max_pixels;
    assign min_dim  = (w_reg < h_reg) ? w_reg : h_reg;

    // The one subtract unit serves both divisions and the square root.
    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            a_op = UW'({rem_reg[DIM_BITS:0], prod_reg[PW-1 -: 2]});
            b_op = UW'({root_reg, 2'b01});
        end
        else
        begin
            a_op = {rem_reg, prod_reg[PW-1]};
            b_op = (state_reg == ST_DIVS) ? UW'(side_eff) : UW'(mp_eff);
        end
        {borrow, diff} = {1'b0, a_op} - {1'b0, b_op};
        fits     = !borrow;
        rem_step = fits ? diff[MW-1:0] : a_op[MW-1:0];
    end

    always_comb
    begin
        upper_val = cfg.min_side_enabled ? SW'(prod_reg[DIM_BITS-1:0])
                                         : dssc_pkg::SIDE_OFF_UPPER;
        if (upper_val < lower_reg)
            initial_val = lower_reg;
        else if (!cfg.max_pixels_enabled && !cfg.min_side_enabled)
            initial_val = SW'(1);
        else if (!cfg.min_side_enabled)
            initial_val = lower_reg;
        else
            initial_val = upper_val;

        round_sum = {1'b0, initial_val} + dssc_pkg::ROUND_MASK;
        if (initial_val <= SW'(1))
            rounded = SW'(1);
        else if (initial_val <= SW'(2))
            rounded = SW'(2);
        else if (initial_val <= SW'(4))
            rounded = SW'(4);
        else if (initial_val <= dssc_pkg::POW2_LIMIT)
            rounded = dssc_pkg::POW2_LIMIT;
        else
            rounded = SW'(round_sum & ~dssc_pkg::ROUND_MASK);
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        w_next      = w_reg;
        h_next      = h_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        lower_next  = lower_reg;
        sample_next = sample_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (start_go)
                begin
                    w_next     = width_in;
                    h_next     = height_in;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = PW'(w_reg) * PW'(h_reg);
                rem_next  = '0;
                cnt_next  = CNT_W'(PW - 1);
                if (cfg.max_pixels_enabled)
                    state_next = ST_DIVQ;
                else
                begin
                    lower_next = SW'(1);
                    state_next = ST_SIDE;
                end
            end
            ST_DIVQ, ST_DIVS:
            begin
                rem_next  = rem_step;
                prod_next = {prod_reg[PW-2:0], fits};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = (state_reg == ST_DIVQ) ? ST_QFIX : ST_FINAL;
            end
            ST_QFIX:
            begin
                prod_next  = prod_reg + PW'(rem_reg != '0);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = CNT_W'(DIM_BITS - 1);
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                rem_next  = rem_step;
                root_next = {root_reg[DIM_BITS-2:0], fits};
                prod_next = {prod_reg[PW-3:0], 2'b00};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_SQFIX;
            end
            ST_SQFIX:
            begin
                if (root_reg == '0)
                    lower_next = SW'(1);
                else
                    lower_next = SW'(root_reg) + SW'(rem_reg != '0);
                state_next = ST_SIDE;
            end
            ST_SIDE:
            begin
                if (cfg.min_side_enabled)
                begin
                    prod_next  = {min_dim, DIM_BITS'(0)};
                    rem_next   = '0;
                    cnt_next   = CNT_W'(DIM_BITS - 1);
                    state_next = ST_DIVS;
                end
                else
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                sample_next = rounded;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        h_reg      <= h_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        lower_reg  <= lower_next;
        sample_reg <= sample_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign sample_size = sample_reg;

endmodule

>>> design/decode_sample_size_chooser.sv
// Top level of the decode sample size chooser: configuration registers and command port.
//
//   Channel   Signals                                   Direction
//   command   start, busy, image_width, image_height    in, busy out
//   result    done, sample_size                         out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in, ready out
//
// The one subtract unit in the sequencer works one bit per cycle on a command; a new
// command is not taken while busy.
// The result is shown with done for one cycle; a new command may be taken in that cycle.
// Reset returns the configuration registers to their documented values and the sequencer to idle.
// The receiver cannot stall; configuration transfers are always ready.
module decode_sample_size_chooser #(
    parameter int DIM_BITS = dssc_pkg::DIM_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dssc_pkg::IMG_W-1:0]      image_width,
    input  logic [dssc_pkg::IMG_W-1:0]      image_height,
    output logic                            done,
    output logic [dssc_pkg::SAMPLE_W-1:0]   sample_size,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dssc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dssc_pkg::CFG_DATA_W-1:0] cfg_data
);

    dssc_pkg::cfg_t cfg_reg, cfg_next;
    logic           cfg_write;
    logic           start_go;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign start_go  = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                dssc_pkg::CFG_MIN_SIDE_LENGTH:
                    cfg_next.min_side_length = cfg_data[dssc_pkg::SIDE_W-1:0];
                dssc_pkg::CFG_MIN_SIDE_ENABLED:
                    cfg_next.min_side_enabled = cfg_data[0];
                dssc_pkg::CFG_MAX_PIXELS:
                    cfg_next.max_pixels = cfg_data[dssc_pkg::MAXPIX_W-1:0];
                dssc_pkg::CFG_MAX_PIXELS_ENABLED:
                    cfg_next.max_pixels_enabled = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_side_length    <= dssc_pkg::RST_MIN_SIDE_LENGTH;
            cfg_reg.min_side_enabled   <= dssc_pkg::RST_MIN_SIDE_ENABLED;
            cfg_reg.max_pixels         <= dssc_pkg::RST_MAX_PIXELS;
            cfg_reg.max_pixels_enabled <= dssc_pkg::RST_MAX_PIXELS_ENABLED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dssc_core #(
        .DIM_BITS (DIM_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_go    (start_go),
        .width_in    (image_width[DIM_BITS-1:0]),
        .height_in   (image_height[DIM_BITS-1:0]),
        .cfg         (cfg_reg),
        .busy        (busy),
        .done        (done),
        .sample_size (sample_size)
    );

endmodule

>>> design/dssc_checker.sv
// Port-level checker of the decode sample size chooser and its bind.
`include "decode_sample_size_chooser_macros.svh"

module dssc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [dssc_pkg::SAMPLE_W-1:0] sample_size
);

    logic shape_ok;

    assign shape_ok = (sample_size <= dssc_pkg::POW2_LIMIT) ? $onehot(sample_size)
                                                            : (sample_size[2:0] == 3'd0);

    `DSSC_ASSERT(a_start_busy, start && !busy |=> busy, "accepted command did not raise busy")
    `DSSC_ASSERT(a_fall_done, $fell(busy) |-> done, "busy fell without a result")
    `DSSC_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
    `DSSC_ASSERT(a_shape, done |-> shape_ok, "sample size not a power of two or multiple of eight")
    `DSSC_ASSERT_ALWAYS(a_reset, !rst_n |=> !busy && !done, "busy or done during reset")

endmodule

bind decode_sample_size_chooser dssc_checker u_dssc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .sample_size (sample_size)
);

>>> verif/sample_size_checker.sv
// Checker for the decode sample size chooser: register shadow, sample size prediction and compare.
module sample_size_checker
    import dssc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [IMG_W-1:0]      image_width,
    input  logic [IMG_W-1:0]      image_height,
    input  logic                  done,
    input  logic [SAMPLE_W-1:0]   sample_size,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t                shadow_cfg;
    logic [SAMPLE_W-1:0] pending_sizes[$];

    function automatic logic [SAMPLE_W-1:0] predict_sample_size(
        input logic [IMG_W-1:0] width,
        input logic [IMG_W-1:0] height,
        input cfg_t             cfg
    );
        logic [63:0] area;
        logic [63:0] pixel_limit;
        logic [63:0] area_ratio;
        logic [63:0] search_lo;
        logic [63:0] search_hi;
        logic [63:0] search_mid;
        logic [63:0] side_limit;
        logic [63:0] shorter_side;
        logic [63:0] factor_floor;
        logic [63:0] factor_ceiling;
        logic [63:0] chosen;
        logic [63:0] rounded;
        factor_floor = 64'd1;
        factor_ceiling = 64'(SIDE_OFF_UPPER);
        if (cfg.max_pixels_enabled)
        begin
            pixel_limit = (cfg.max_pixels == '0) ? 64'd1 : 64'(cfg.max_pixels);
            area = 64'(width);
            area = area * 64'(height);
            area_ratio = (area + pixel_limit - 64'd1) / pixel_limit;
            search_lo = 64'd1;
            search_hi = 64'd65536;
            while (search_lo < search_hi)
            begin
                search_mid = (search_lo + search_hi) >> 1;
                if (search_mid * search_mid >= area_ratio)
                    search_hi = search_mid;
                else
                    search_lo = search_mid + 64'd1;
            end
            factor_floor = search_lo;
        end
        if (cfg.min_side_enabled)
        begin
            side_limit = (cfg.min_side_length == '0) ? 64'd1 : 64'(cfg.min_side_length);
            shorter_side = (width < height) ? 64'(width) : 64'(height);
            factor_ceiling = shorter_side / side_limit;
        end
        if (factor_ceiling < factor_floor)
            chosen = factor_floor;
        else if (!cfg.max_pixels_enabled && !cfg.min_side_enabled)
            chosen = 64'd1;
        else if (!cfg.min_side_enabled)
            chosen = factor_floor;
        else
            chosen = factor_ceiling;
        if (chosen <= 64'(POW2_LIMIT))
        begin
            rounded = 64'd1;
            while (rounded < chosen)
                rounded = rounded << 1;
        end
        else
        begin
            rounded = (chosen + 64'd7) / 64'd8 * 64'd8;
        end
        return rounded[SAMPLE_W-1:0];
    endfunction

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [SAMPLE_W-1:0] expected_size;
        if (!rst_n)
        begin
            shadow_cfg.min_side_length = RST_MIN_SIDE_LENGTH;
            shadow_cfg.min_side_enabled = RST_MIN_SIDE_ENABLED;
            shadow_cfg.max_pixels = RST_MAX_PIXELS;
            shadow_cfg.max_pixels_enabled = RST_MAX_PIXELS_ENABLED;
            pending_sizes.delete();
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_sizes.size() == 0)
                begin
                    $error("sample_size: expected none, actual %0d", sample_size);
                    mismatches++;
                end
                else
                begin
                    expected_size = pending_sizes.pop_front();
                    if (sample_size !== expected_size)
                    begin
                        $error("sample_size: expected %0d, actual %0d",
                               expected_size, sample_size);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                pending_sizes.push_back(
                    predict_sample_size(image_width, image_height, shadow_cfg));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_SIDE_LENGTH:    shadow_cfg.min_side_length = cfg_data[SIDE_W-1:0];
                    CFG_MIN_SIDE_ENABLED:   shadow_cfg.min_side_enabled = cfg_data[0];
                    CFG_MAX_PIXELS:         shadow_cfg.max_pixels = cfg_data[MAXPIX_W-1:0];
                    CFG_MAX_PIXELS_ENABLED: shadow_cfg.max_pixels_enabled = cfg_data[0];
                    default: ;
                endcase
            end
            outstanding = pending_sizes.size();
        end
    end

endmodule

>>> verif/decode_sample_size_chooser_test.sv
// Testbench top for the decode sample size chooser: stimulus, register settings and verdict.
module decode_sample_size_chooser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dssc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int RANDOM_SETTINGS = 10;
    localparam int DRAIN_CYCLES    = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(4);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [IMG_W-1:0]      image_width = '0;
    logic [IMG_W-1:0]      image_height = '0;
    logic                  done;
    logic [SAMPLE_W-1:0]   sample_size;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int directed_count = 0;
    int random_count = 0;
    int setting_count = 0;
    bit allow_idle = 1'b1;

    decode_sample_size_chooser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .image_width  (image_width),
        .image_height (image_height),
        .done         (done),
        .sample_size  (sample_size),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sample_size_checker sample_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .image_width  (image_width),
        .image_height (image_height),
        .done         (done),
        .sample_size  (sample_size),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic idle_gap();
        while (allow_idle && $urandom_range(0, 99) < 9)
            @(negedge clk);
    endtask

    task automatic issue_command(input logic [IMG_W-1:0] width, input logic [IMG_W-1:0] height);
        @(negedge clk);
        while (busy || (allow_idle && $urandom_range(0, 99) < 9))
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        image_width <= width;
        image_height <= height;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        idle_gap();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] side_data,
                                 input logic [CFG_DATA_W-1:0] side_enable_data,
                                 input logic [CFG_DATA_W-1:0] pixel_data,
                                 input logic [CFG_DATA_W-1:0] pixel_enable_data);
        wait_drained();
        write_register(CFG_MIN_SIDE_LENGTH, side_data);
        write_register(CFG_MIN_SIDE_ENABLED, side_enable_data);
        write_register(CFG_MAX_PIXELS, pixel_data);
        write_register(CFG_MAX_PIXELS_ENABLED, pixel_enable_data);
        setting_count++;
    endtask

    task automatic directed_command(input logic [IMG_W-1:0] width,
                                    input logic [IMG_W-1:0] height);
        issue_command(width, height);
        directed_count++;
    endtask

    function automatic logic [IMG_W-1:0] pick_dimension();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return IMG_W'(1);
            2:       return '1;
            3, 4, 5, 6, 7:
                     return IMG_W'($urandom_range(1, 64));
            8, 9, 10, 11, 12, 13:
                     return IMG_W'($urandom_range(64, 8192));
            default: return IMG_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_side_length();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(16'hFFFF);
            3:       return CFG_DATA_W'($urandom_range(2, 64));
            4:       return CFG_DATA_W'($urandom_range(64, 1024));
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_pixel_limit();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return '1;
            3:       return CFG_DATA_W'($urandom_range(2, 4096));
            4, 5:    return CFG_DATA_W'($urandom_range(65536, 4194304));
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] side_enable_data;
        logic [CFG_DATA_W-1:0] pixel_enable_data;
        int items_per_setting;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Power-on settings: pixel limit alone.
        directed_command(16'd1, 16'd1);
        directed_command(16'd0, 16'd0);
        directed_command(16'd0, 16'd500);
        directed_command(16'd500, 16'd0);
        directed_command(16'hFFFF, 16'hFFFF);
        directed_command(16'hFFFF, 16'd1);
        directed_command(16'd1, 16'hFFFF);
        directed_command(16'd443, 16'd443);
        directed_command(16'd444, 16'd443);
        directed_command(16'd4032, 16'd3024);

        apply_setting(32'd96, 32'd0, 32'd196608, 32'd0);
        directed_command(16'hFFFF, 16'hFFFF);
        directed_command(16'd3, 16'd7);

        apply_setting(32'd96, 32'd1, 32'd196608, 32'd0);
        directed_command(16'd96, 16'd96);
        directed_command(16'd1000, 16'd2000);
        directed_command(16'hFFFF, 16'hFFFF);

        apply_setting(32'd0, 32'd1, 32'd0, 32'd1);
        write_register(CFG_UNMAPPED, 32'hFFFF_FFFF);
        directed_command(16'd100, 16'd1);
        directed_command(16'hFFFF, 16'hFFFF);
        directed_command(16'd0, 16'd9);

        apply_setting(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed_command(16'hFFFF, 16'hFFFF);
        directed_command(16'hFFFF, 16'd100);

        items_per_setting = RANDOM_ITEMS / RANDOM_SETTINGS;
        for (int s = 0; s < RANDOM_SETTINGS; s++)
        begin
            allow_idle = (s != 4 && s != 5);
            side_enable_data = $urandom();
            pixel_enable_data = $urandom();
            case (s)
                0:       apply_setting(32'd1, side_enable_data | 32'd1,
                                       32'd1, pixel_enable_data | 32'd1);
                1:       apply_setting(32'hFFFF_FFFF, side_enable_data | 32'd1,
                                       32'hFFFF_FFFF, pixel_enable_data | 32'd1);
                2:       apply_setting(32'd0, side_enable_data & ~32'd1,
                                       32'd0, pixel_enable_data | 32'd1);
                default: apply_setting(pick_side_length(), side_enable_data,
                                       pick_pixel_limit(), pixel_enable_data);
            endcase
            if ($urandom_range(0, 2) == 0)
                write_register(CFG_IDX_W'($urandom_range(4, 255)), $urandom());
            for (int n = 0; n < items_per_setting; n++)
            begin
                issue_command(pick_dimension(), pick_dimension());
                random_count++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d directed and %0d random commands across %0d register settings.",
                 directed_count, random_count, setting_count);
        $display("Settings spanned pixel and side limits on and off, zero and full-scale values.");
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/dssc_pkg.sv
design/dssc_core.sv
design/decode_sample_size_chooser.sv
design/dssc_checker.sv
verif/sample_size_checker.sv
verif/decode_sample_size_chooser_test.sv
